// File: hdl/wfba_pkg.sv
// Shared constants, command type and field conversion helpers for the worst-fit allocator.
package wfba_pkg;

  localparam int NUM_BLOCKS = 32;
  localparam int SIZE_BITS  = 16;

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

  // Port field widths
  localparam int FLD_ACT_W  = 2;
  localparam int FLD_SIZE_W = 16;
  localparam int FLD_STAT_W = 2;
  localparam int FLD_IDX_W  = 5;

  // Command queue between the front and the back end
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Action codes
  localparam logic [FLD_ACT_W-1:0] ACT_LOAD  = 2'd0;
  localparam logic [FLD_ACT_W-1:0] ACT_ALLOC = 2'd1;
  localparam logic [FLD_ACT_W-1:0] ACT_CLEAR = 2'd2;
  localparam logic [FLD_ACT_W-1:0] ACT_RSVD  = 2'd3;

  // Status codes
  localparam logic [FLD_STAT_W-1:0] STAT_LOADED = 2'd0;
  localparam logic [FLD_STAT_W-1:0] STAT_ALLOC  = 2'd1;
  localparam logic [FLD_STAT_W-1:0] STAT_MISS   = 2'd2;
  localparam logic [FLD_STAT_W-1:0] STAT_NONE   = 2'd3;

  // Command kinds, decided by the front end
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_ALLOC = 2'd1;
  localparam logic [1:0] CMD_MISS  = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  typedef struct packed {
    logic [1:0]           kind;
    logic [IDX_W-1:0]     idx;
    logic [CNT_W-1:0]     count;
    logic [SIZE_BITS-1:0] size;
  } cmd_t;

  function automatic logic [SIZE_BITS-1:0] fld_to_size(input logic [FLD_SIZE_W-1:0] f);
    logic [63:0] t;
    t = 64'(f);
    return t[SIZE_BITS-1:0];
  endfunction

  function automatic logic [FLD_SIZE_W-1:0] size_to_fld(input logic [SIZE_BITS-1:0] s);
    logic [63:0] t;
    t = 64'(s);
    return t[FLD_SIZE_W-1:0];
  endfunction

  function automatic logic [FLD_IDX_W-1:0] idx_to_fld(input logic [IDX_W-1:0] i);
    logic [31:0] t;
    t = 32'(i);
    return t[FLD_IDX_W-1:0];
  endfunction

endpackage

// File: hdl/wfba_if.sv
// Valid/ready channel interfaces for requests and results.
interface wfba_in_if import wfba_pkg::*; ;
  logic                  valid;
  logic                  ready;
  logic [FLD_ACT_W-1:0]  action;
  logic [FLD_SIZE_W-1:0] size;

  modport source (output valid, action, size, input ready);
  modport sink   (input valid, action, size, output ready);
endinterface

interface wfba_out_if import wfba_pkg::*; ;
  logic                  valid;
  logic                  ready;
  logic [FLD_STAT_W-1:0] status;
  logic [FLD_IDX_W-1:0]  block_index;
  logic [FLD_SIZE_W-1:0] original_size;
  logic [FLD_SIZE_W-1:0] leftover;

  modport source (output valid, status, block_index, original_size, leftover, input ready);
  modport sink   (input valid, status, block_index, original_size, leftover, output ready);
endinterface

// File: hdl/wfba_front.sv
// Front end: accepts requests, keeps the block count and classifies each request.
module wfba_front import wfba_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  wfba_in_if.sink   req,
  input  logic      q_full,
  output logic      push,
  output cmd_t      cmd
);

  logic [CNT_W-1:0]     block_count;
  logic [CNT_W-1:0]     block_count_next;
  logic                 tbl_full;

  assign req.ready = !q_full;
  assign push      = req.valid && !q_full;
  assign tbl_full  = (block_count == CNT_W'(NUM_BLOCKS));

  always_comb begin
    cmd.size         = fld_to_size(req.size);
    cmd.count        = block_count;
    cmd.idx          = block_count[IDX_W-1:0];
    cmd.kind         = CMD_NONE;
    block_count_next = block_count;
    unique case (req.action) inside
      ACT_LOAD: begin
        if (!tbl_full) begin
          cmd.kind         = CMD_LOAD;
          block_count_next = block_count + CNT_W'(1);
        end
      end
      ACT_ALLOC: begin
        cmd.kind = (block_count == '0) ? CMD_MISS : CMD_ALLOC;
      end
      ACT_CLEAR, ACT_RSVD: begin
        block_count_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= '0;
    end else if (push) begin
      block_count <= block_count_next;
    end
  end

endmodule

// File: hdl/wfba_queue.sv
// Short command queue between the front end and the back end.
module wfba_queue import wfba_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output logic vld,
  output cmd_t dout
);

  cmd_t              ent [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign full = (fill == QCNT_W'(QDEPTH));
  assign vld  = (fill != '0);
  assign dout = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= next_ptr(wr_ptr);
      if (pop)  rd_ptr <= next_ptr(rd_ptr);
      if (push && !pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent[wr_ptr] <= din;
  end

endmodule

// File: hdl/wfba_back.sv
// Back end: block tables, worst-fit scan sequencer and result register.
module wfba_back import wfba_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_vld,
  input  cmd_t       cmd,
  output logic       pop,
  wfba_out_if.source rsp
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [SIZE_BITS-1:0] rem_mem  [NUM_BLOCKS];
  logic [SIZE_BITS-1:0] orig_mem [NUM_BLOCKS];

  logic [1:0]            state;
  cmd_t                  cur;
  logic [CNT_W-1:0]      issue_cnt;
  logic                  dvld;
  logic [IDX_W-1:0]      didx;
  logic [SIZE_BITS-1:0]  rem_q;
  logic [SIZE_BITS-1:0]  orig_q;
  logic                  found;
  logic [IDX_W-1:0]      best_idx;
  logic [SIZE_BITS-1:0]  best_left;
  logic [SIZE_BITS-1:0]  best_orig;

  logic                  out_vld;
  logic [FLD_STAT_W-1:0] out_status;
  logic [FLD_IDX_W-1:0]  out_idx;
  logic [FLD_SIZE_W-1:0] out_orig;
  logic [FLD_SIZE_W-1:0] out_left;

  logic                  can_emit;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic                  fit;
  logic [SIZE_BITS-1:0]  left;
  logic                  better;
  logic                  we_rem;
  logic                  we_orig;
  logic [IDX_W-1:0]      wa;
  logic [SIZE_BITS-1:0]  wd_rem;
  logic                  emit;
  logic [FLD_STAT_W-1:0] e_status;
  logic [IDX_W-1:0]      e_idx;
  logic [SIZE_BITS-1:0]  e_orig;
  logic [SIZE_BITS-1:0]  e_left;

  assign can_emit = !out_vld || rsp.ready;
  assign pop      = (state == S_IDLE) && cmd_vld && can_emit;
  assign rd_en    = (state == S_SCAN) && (issue_cnt != cur.count);
  assign rd_addr  = issue_cnt[IDX_W-1:0];

  // Compare the entry read last cycle against the best so far
  assign fit    = (rem_q >= cur.size);
  assign left   = rem_q - cur.size;
  assign better = dvld && fit && (!found || (left > best_left));

  always_comb begin
    we_rem   = 1'b0;
    we_orig  = 1'b0;
    wa       = cmd.idx;
    wd_rem   = cmd.size;
    emit     = 1'b0;
    e_status = STAT_NONE;
    e_idx    = '0;
    e_orig   = '0;
    e_left   = '0;
    if (pop) begin
      unique case (cmd.kind)
        CMD_LOAD: begin
          we_rem   = 1'b1;
          we_orig  = 1'b1;
          emit     = 1'b1;
          e_status = STAT_LOADED;
          e_idx    = cmd.idx;
          e_orig   = cmd.size;
          e_left   = cmd.size;
        end
        CMD_ALLOC: begin
          emit = 1'b0;
        end
        CMD_MISS: begin
          emit     = 1'b1;
          e_status = STAT_MISS;
        end
        CMD_NONE: begin
          emit     = 1'b1;
          e_status = STAT_NONE;
        end
      endcase
    end
    if ((state == S_DONE) && can_emit) begin
      emit = 1'b1;
      if (found) begin
        we_rem   = 1'b1;
        wa       = best_idx;
        wd_rem   = best_left;
        e_status = STAT_ALLOC;
        e_idx    = best_idx;
        e_orig   = best_orig;
        e_left   = best_left;
      end else begin
        e_status = STAT_MISS;
      end
    end
  end

  // Block tables: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (we_rem)  rem_mem[wa]  <= wd_rem;
    if (we_orig) orig_mem[wa] <= cmd.size;
    if (rd_en) begin
      rem_q  <= rem_mem[rd_addr];
      orig_q <= orig_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issue_cnt <= '0;
      dvld      <= 1'b0;
      found     <= 1'b0;
      out_vld   <= 1'b0;
    end else begin
      dvld <= rd_en;
      if (emit) begin
        out_vld <= 1'b1;
      end else if (rsp.ready) begin
        out_vld <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            issue_cnt <= '0;
            found     <= 1'b0;
            if (cmd.kind == CMD_ALLOC) state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_en)  issue_cnt <= issue_cnt + CNT_W'(1);
          if (better) found <= 1'b1;
          if (!rd_en && !dvld) state <= S_DONE;
        end
        S_DONE: begin
          if (can_emit) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= cmd;
    didx <= rd_addr;
    if (better) begin
      best_idx  <= didx;
      best_left <= left;
      best_orig <= orig_q;
    end
    if (emit) begin
      out_status <= e_status;
      out_idx    <= idx_to_fld(e_idx);
      out_orig   <= size_to_fld(e_orig);
      out_left   <= size_to_fld(e_left);
    end
  end

  assign rsp.valid         = out_vld;
  assign rsp.status        = out_status;
  assign rsp.block_index   = out_idx;
  assign rsp.original_size = out_orig;
  assign rsp.leftover      = out_left;

endmodule

// File: hdl/worst_fit_block_allocator.sv
// Worst-fit allocator: load, clear and no-fit results pass through the command queue
// and the result register. An allocate scans in the back end with one read of the
// remaining-size table per loaded block. Other commands leave the back end at one
// per cycle while results are taken and no scan runs; the front keeps taking requests
// while the short command queue has room. Synchronous reset empties the table count,
// the queue, the sequencer and the result register; the block tables are not cleared.
module worst_fit_block_allocator import wfba_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  wfba_in_if.sink    req,
  wfba_out_if.source rsp
);

  // Front to queue
  logic q_push;
  logic q_full;
  cmd_t q_din;

  // Queue to back end
  logic q_pop;
  logic q_vld;
  cmd_t q_dout;

  // Front end: decode action, track the block count, decide load slot and scan length
  wfba_front u_front (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .q_full (q_full),
    .push   (q_push),
    .cmd    (q_din)
  );

  // Queue: let the front keep accepting while the back end scans
  wfba_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (q_din),
    .full (q_full),
    .pop  (q_pop),
    .vld  (q_vld),
    .dout (q_dout)
  );

  // Back end: tables, worst-fit scan and the result register that holds
  // each result until its transfer
  wfba_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cmd_vld (q_vld),
    .cmd     (q_dout),
    .pop     (q_pop),
    .rsp     (rsp)
  );

`ifndef SYNTHESIS
  // The back end only draws a command that is present
  a_pop_has_cmd: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_vld)
    else $error("command popped from empty queue");

  // A loaded block reports equal original and remaining sizes
  a_load_sizes: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status == STAT_LOADED)) |-> (rsp.original_size == rsp.leftover))
    else $error("load result sizes differ");

  // Remaining size never grows past the original size
  a_alloc_shrinks: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status == STAT_ALLOC)) |-> (rsp.leftover <= rsp.original_size))
    else $error("allocation leftover exceeds original size");

  // Results without a block carry zero fields
  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && ((rsp.status == STAT_MISS) || (rsp.status == STAT_NONE))) |->
      ((rsp.block_index == '0) && (rsp.original_size == '0) && (rsp.leftover == '0)))
    else $error("non-block result has nonzero fields");
`endif

endmodule
